FILE: src/htrf_pkg.sv
package htrf_pkg;

  // Default number of front-end boards with per-board state
  localparam int unsigned HTRF_BOARDS = 32;

  // Stream and register port widths
  localparam int unsigned IN_W      = 200;
  localparam int unsigned OUT_W     = 224;
  localparam int unsigned ADDR_BITS = 5;
  localparam int unsigned DATA_BITS = 64;
  localparam int unsigned TOL_BITS  = 40;

  // Register indexes, taken from paddr[4:3]
  localparam logic [1:0] REG_DROP_SYNC  = 2'd0;
  localparam logic [1:0] REG_DROP_ORDER = 2'd1;
  localparam logic [1:0] REG_SYNC_TOL   = 2'd2;

  // Time constants
  localparam logic [29:0]        NS_PER_SEC = 30'd1000000000;
  localparam logic signed [30:0] HALF_SEC   = 31'sd500000000;
  // Offset sum is biased by two seconds so that it is never negative
  localparam logic [31:0]        SUM_BIAS   = 32'd2000000000;
  localparam int unsigned        FOLD_IN    = 4;

  // floor(2^61 / 1e9); quotient estimate falls short by at most two
  localparam logic [31:0] RECIP_NS    = 32'd2305843009;
  localparam int unsigned RECIP_SHIFT = 29;
  localparam int unsigned FOLD_MEAN   = 3;

  typedef struct packed {
    logic [63:0] last_ns;
    logic [31:0] drops;
  } entry_t;

  typedef struct packed {
    logic        in_range;
    logic [4:0]  board;
    logic [63:0] lo;
    logic [63:0] hi;
  } hit_ctx_t;

endpackage

FILE: src/hit_timestamp_rebuild_filter.sv
// Hit timestamp rebuild and filter. Each input beat is one detector hit; each produces exactly
// one output beat, in order, and a new hit can be taken on every cycle unless the output is
// stalled. The rebuilt time is the offset-corrected nanosecond count placed in the second
// nearest the mean poll time; m_axis_tuser is 1 when the hit passed the filters. Per-board
// state (last accepted time and a saturating dropped count) lives in one memory with a registered
// read, read as a hit enters the last stage and written back as it leaves, with a bypass when two
// consecutive hits come from the same board; a valid bit per board makes an unwritten entry read
// as zero, so no clearing pass is needed after reset. The throughput of one hit per cycle is set
// by that read-modify-write loop when the output is not stalled. Registers sit at byte addresses
// 0x00 (drop out-of-sync hits), 0x08 (drop out-of-order hits) and 0x10 (40-bit sync tolerance
// in ns); write them only while no hit is in flight.
module hit_timestamp_rebuild_filter
  import htrf_pkg::*;
#(
  parameter int unsigned BOARD_COUNT = HTRF_BOARDS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // board_index[4:0], ns_in_second[34:5], cable_offset_ns[65:35],
  // window_start_ns[129:66], window_end_ns[193:130], zero pad [199:194]
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // full_time_ns[63:0], sequence_number[127:64], dropped_before[159:128],
  // previous_accepted_ns[223:160]
  output logic [OUT_W-1:0]     m_axis_tdata,
  // accepted[0]
  output logic [0:0]           m_axis_tuser,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  localparam int unsigned ADDR_W      = (BOARD_COUNT > 1) ? $clog2(BOARD_COUNT) : 1;
  localparam logic [8:0]  BOARD_LIMIT = 9'(BOARD_COUNT);
  localparam int unsigned NSTAGE      = 9;

  // ---------------------------------------------------------------- registers
  logic                cfg_sync_q;
  logic                cfg_ord_q;
  logic [TOL_BITS-1:0] cfg_tol_q;
  logic [1:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sync_q <= 1'b0;
      cfg_ord_q  <= 1'b0;
      cfg_tol_q  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_DROP_SYNC:  cfg_sync_q <= pwdata[0];
        REG_DROP_ORDER: cfg_ord_q  <= pwdata[0];
        REG_SYNC_TOL:   cfg_tol_q  <= pwdata[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DROP_SYNC:  prdata = {63'b0, cfg_sync_q};
      REG_DROP_ORDER: prdata = {63'b0, cfg_ord_q};
      REG_SYNC_TOL:   prdata = {24'b0, cfg_tol_q};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- pipeline control
  logic [NSTAGE+1:1] en;
  logic [NSTAGE:1]   v_q;
  logic              out_v_q;

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    en[NSTAGE+1] = ~out_v_q | m_axis_tready;
    for (int k = NSTAGE; k >= 1; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign s_axis_tready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (en[1]) v_q[1] <= s_axis_tvalid;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
      if (en[NSTAGE+1]) out_v_q <= v_q[NSTAGE];
    end
  end

  // ---------------------------------------------------------------- stage 1: capture
  logic [4:0]  in_board;
  logic [29:0] in_ns;
  logic [30:0] in_off;
  logic [63:0] in_ws;
  logic [63:0] in_we;
  logic [63:0] tol64;
  logic [64:0] hi_sum;
  hit_ctx_t    ctx_d;
  logic [63:0] mean1_d;
  logic [31:0] sum1_d;

  assign in_board = s_axis_tdata[4:0];
  assign in_ns    = s_axis_tdata[34:5];
  assign in_off   = s_axis_tdata[65:35];
  assign in_ws    = s_axis_tdata[129:66];
  assign in_we    = s_axis_tdata[193:130];
  assign tol64    = 64'(cfg_tol_q);
  assign hi_sum   = {1'b0, in_we} + 65'(cfg_tol_q);

  always_comb begin
    ctx_d.in_range = ({4'b0, in_board} < BOARD_LIMIT);
    ctx_d.board    = in_board;
    ctx_d.lo       = (in_ws > tol64) ? (in_ws - tol64) : '0;
    ctx_d.hi       = hi_sum[64] ? '1 : hi_sum[63:0];
    mean1_d        = {1'b0, in_ws[63:1]} + {1'b0, in_we[63:1]};
    sum1_d         = {2'b0, in_ns} + {in_off[30], in_off} + SUM_BIAS;
  end

  hit_ctx_t    ctx_q [1:NSTAGE];
  logic [63:0] mean1_q, mean2_q, mean3_q, mean4_q, mean5_q, mean6_q;
  logic [31:0] sum1_q;
  logic [63:0] plo2_q, phi2_q;
  logic [29:0] t2_q, t3_q, t4_q, t5_q, t6_q;
  logic [31:0] q3_q;
  logic [31:0] qd4_q;
  logic [31:0] r5_q;
  logic [29:0] mns6_q;
  logic [63:0] base7_q;
  logic        up7_q, dn7_q;
  logic [63:0] ts8_q, ts9_q;

  // ---------------------------------------------------------------- datapath
  logic [31:0]        t_full;
  logic [29:0]        t2_d;
  logic [63:0]        plo2_d, phi2_d;
  logic [63:0]        qsum;
  logic [31:0]        q3_d;
  logic [31:0]        qd4_d;
  logic [31:0]        r5_d;
  logic [31:0]        mns_full;
  logic [29:0]        mns6_d;
  logic signed [30:0] diff7;
  logic [63:0]        base7_d;
  logic [63:0]        ts8_d;

  always_comb begin
    // fold the biased offset sum into one second
    t_full = sum1_q;
    for (int k = 1; k <= FOLD_IN; k++) begin
      if (sum1_q >= 32'(k) * {2'b0, NS_PER_SEC}) t_full = sum1_q - 32'(k) * {2'b0, NS_PER_SEC};
    end
    t2_d = t_full[29:0];

    plo2_d = 64'(mean1_q[31:0]) * 64'(RECIP_NS);
    phi2_d = 64'(mean1_q[63:32]) * 64'(RECIP_NS);

    qsum = phi2_q + {32'b0, plo2_q[63:32]};
    q3_d = qsum[RECIP_SHIFT+31:RECIP_SHIFT];

    qd4_d = q3_q * {2'b0, NS_PER_SEC};
    r5_d  = mean4_q[31:0] - qd4_q;

    // remainder estimate is below three seconds: finish it
    mns_full = r5_q;
    for (int k = 1; k <= FOLD_MEAN; k++) begin
      if (r5_q >= 32'(k) * {2'b0, NS_PER_SEC}) mns_full = r5_q - 32'(k) * {2'b0, NS_PER_SEC};
    end
    mns6_d = mns_full[29:0];

    diff7   = $signed({1'b0, t6_q}) - $signed({1'b0, mns6_q});
    base7_d = mean6_q - 64'(mns6_q) + 64'(t6_q);

    // move to the neighbouring second when the hit lies over half a second away
    if (up7_q) begin
      ts8_d = base7_q + 64'(NS_PER_SEC);
    end else if (dn7_q) begin
      ts8_d = base7_q - 64'(NS_PER_SEC);
    end else begin
      ts8_d = base7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ctx_q[1] <= ctx_d;
      mean1_q  <= mean1_d;
      sum1_q   <= sum1_d;
    end
    for (int k = 2; k <= NSTAGE; k++) begin
      if (en[k]) ctx_q[k] <= ctx_q[k-1];
    end
    if (en[2]) begin
      plo2_q  <= plo2_d;
      phi2_q  <= phi2_d;
      mean2_q <= mean1_q;
      t2_q    <= t2_d;
    end
    if (en[3]) begin
      q3_q    <= q3_d;
      mean3_q <= mean2_q;
      t3_q    <= t2_q;
    end
    if (en[4]) begin
      qd4_q   <= qd4_d;
      mean4_q <= mean3_q;
      t4_q    <= t3_q;
    end
    if (en[5]) begin
      r5_q    <= r5_d;
      mean5_q <= mean4_q;
      t5_q    <= t4_q;
    end
    if (en[6]) begin
      mns6_q  <= mns6_d;
      mean6_q <= mean5_q;
      t6_q    <= t5_q;
    end
    if (en[7]) begin
      base7_q <= base7_d;
      up7_q   <= (diff7 < -HALF_SEC);
      dn7_q   <= (diff7 > HALF_SEC);
    end
    if (en[8]) ts8_q <= ts8_d;
    if (en[9]) ts9_q <= ts8_q;
  end

  // ---------------------------------------------------------------- per-board state
  entry_t                 state_mem [BOARD_COUNT];
  entry_t                 mem_rd_q;
  entry_t                 fwd_data_q;
  logic                   fwd_q;
  logic                   hit_q;
  logic [BOARD_COUNT-1:0] seen_q;

  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] raddr, waddr;
  entry_t            wdata;
  entry_t            ent;
  hit_ctx_t          ctx9;
  hit_ctx_t          ctx8;

  assign ctx8  = ctx_q[NSTAGE-1];
  assign ctx9  = ctx_q[NSTAGE];
  assign raddr = ctx8.in_range ? ADDR_W'(ctx8.board) : '0;
  assign waddr = ctx9.in_range ? ADDR_W'(ctx9.board) : '0;
  assign rd_en = en[NSTAGE] & v_q[NSTAGE-1] & ctx8.in_range;
  assign wr_en = en[NSTAGE+1] & v_q[NSTAGE] & ctx9.in_range;

  always_ff @(posedge clk_i) begin
    if (wr_en) state_mem[waddr] <= wdata;
    if (rd_en) mem_rd_q <= state_mem[raddr];
  end

  // bypass the write of the hit ahead when it hits the same board
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q  <= 1'b0;
      hit_q  <= 1'b0;
      seen_q <= '0;
    end else begin
      if (en[NSTAGE]) begin
        fwd_q <= wr_en & (waddr == raddr);
        hit_q <= seen_q[raddr];
      end
      if (wr_en) seen_q[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTAGE]) fwd_data_q <= wdata;
  end

  // ---------------------------------------------------------------- filter and result
  logic [63:0] seq_q;
  logic        drop_sync, drop_ord, keep;
  logic [31:0] drops_inc;
  logic        acc_d;
  logic [63:0] seq_d, prev_d;
  logic [31:0] dcnt_d;

  always_comb begin
    ent       = fwd_q ? fwd_data_q : (hit_q ? mem_rd_q : '0);
    drop_sync = cfg_sync_q & ((ts9_q < ctx9.lo) | (ts9_q > ctx9.hi));
    drop_ord  = cfg_ord_q & (ts9_q <= ent.last_ns);
    keep      = ctx9.in_range & ~(drop_sync | drop_ord);
    drops_inc = (&ent.drops) ? ent.drops : ent.drops + 32'd1;

    acc_d  = 1'b0;
    seq_d  = '0;
    dcnt_d = '0;
    prev_d = '0;
    wdata  = ent;
    if (keep) begin
      acc_d         = 1'b1;
      seq_d         = seq_q;
      dcnt_d        = ent.drops;
      prev_d        = (ent.drops != '0) ? ent.last_ns : '0;
      wdata.last_ns = ts9_q;
      wdata.drops   = '0;
    end else if (ctx9.in_range) begin
      dcnt_d      = drops_inc;
      prev_d      = ent.last_ns;
      wdata.drops = drops_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
    end else if (wr_en && keep) begin
      seq_q <= seq_q + 64'd1;
    end
  end

  logic        out_acc_q;
  logic [63:0] out_time_q, out_seq_q, out_prev_q;
  logic [31:0] out_drop_q;

  // hold the result beat until it is taken
  always_ff @(posedge clk_i) begin
    if (en[NSTAGE+1]) begin
      out_acc_q  <= acc_d;
      out_time_q <= ts9_q;
      out_seq_q  <= seq_d;
      out_drop_q <= dcnt_d;
      out_prev_q <= prev_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_prev_q, out_drop_q, out_seq_q, out_time_q};
  assign m_axis_tuser  = out_acc_q;

endmodule

FILE: tb/tb_hit_timestamp_rebuild_filter.sv
`timescale 1ns / 1ps

module tb_hit_timestamp_rebuild_filter
  import htrf_pkg::*;
();

  localparam longint SEC_NS      = 1000000000;
  localparam longint HALF_NS     = 500000000;
  localparam int     HOLD_CYCLES = 400;
  localparam int     STALL_LIMIT = 5000;

  typedef struct packed {
    logic [4:0]  board;
    logic [29:0] ns;
    logic [30:0] off;
    logic [63:0] ws;
    logic [63:0] we;
  } hit_t;

  typedef struct {
    bit          accepted;
    logic [63:0] full_ns;
    logic [63:0] seq;
    logic [31:0] drops;
    logic [63:0] prev;
  } hit_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  hit_timestamp_rebuild_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial forever #5 clk_i = ~clk_i;

  // Register copies and per-board history mirrored from the block
  bit          drop_sync = 1'b0;
  bit          drop_order = 1'b0;
  logic [39:0] tol_ns = '0;
  logic [63:0] board_last_ns [32];
  logic [31:0] board_drops [32];
  logic [63:0] accept_count = '0;

  hit_t        pending_hits[$];
  hit_result_t expected_results[$];
  hit_t        cur_hit;
  int          hit_gap = 0;
  int          hits_sent = 0;
  int          results_seen = 0;
  int          out_stall = 0;
  int          out_hold = 0;
  int          idle_cycles = 0;
  int          fail_count = 0;
  int          kept_total = 0;
  int          dropped_total = 0;
  bit          busy;
  bit          ready;

  // Stimulus shaping
  logic [63:0] now_ns;
  logic [63:0] last_at [32];
  logic [30:0] board_cable [32];

  function automatic logic [63:0] rebuild_ns(hit_t h);
    longint      off_v, t, mean_off, delta;
    logic [63:0] mean, base;
    off_v = $signed(h.off);
    t = (longint'({34'd0, h.ns}) + off_v) % SEC_NS;
    if (t < 0) t += SEC_NS;
    mean = (h.ws >> 1) + (h.we >> 1);
    mean_off = mean % 64'd1000000000;
    base = mean - mean_off + t;
    delta = t - mean_off;
    // Move to the neighbouring second when more than half a second away
    if (delta < -HALF_NS) base += 64'd1000000000;
    else if (delta > HALF_NS) base -= 64'd1000000000;
    return base;
  endfunction

  task automatic predict_hit(input hit_t h);
    hit_result_t r;
    logic [63:0] ts, lo, hi, tol;
    logic [31:0] cnt;
    bit          drop;
    int          b;
    b = h.board;
    ts = rebuild_ns(h);
    tol = {24'd0, tol_ns};
    drop = 1'b0;
    if (drop_sync) begin
      lo = (h.ws > tol) ? h.ws - tol : 64'd0;
      hi = h.we + tol;
      if (hi < h.we) hi = '1;
      drop = (ts < lo) || (ts > hi);
    end
    if (!drop && drop_order && ts <= board_last_ns[b]) drop = 1'b1;
    cnt = board_drops[b];
    r.full_ns = ts;
    if (drop) begin
      if (cnt != '1) cnt++;
      board_drops[b] = cnt;
      r.accepted = 1'b0;
      r.seq = '0;
      r.drops = cnt;
      r.prev = board_last_ns[b];
      dropped_total++;
    end else begin
      r.accepted = 1'b1;
      r.seq = accept_count;
      r.drops = cnt;
      r.prev = (cnt != 0) ? board_last_ns[b] : 64'd0;
      board_drops[b] = '0;
      board_last_ns[b] = ts;
      accept_count++;
      kept_total++;
    end
    expected_results = {expected_results, r};
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("result %0d, %s: got 0x%h, expected 0x%h", results_seen, field, got, want);
    fail_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic hit_t make_hit(logic [4:0] b, logic [29:0] ns, logic [30:0] off,
                                    logic [63:0] ws, logic [63:0] we);
    hit_t h;
    h.board = b;
    h.ns = ns;
    h.off = off;
    h.ws = ws;
    h.we = we;
    return h;
  endfunction

  // Choose ns_in_second so that the corrected time lands on the given absolute time
  function automatic hit_t hit_at(logic [4:0] b, logic [63:0] at, logic [30:0] off,
                                  logic [63:0] ws, logic [63:0] we);
    longint off_v, v;
    off_v = $signed(off);
    v = longint'(at % 64'd1000000000) - off_v;
    v = v % SEC_NS;
    if (v < 0) v += SEC_NS;
    return make_hit(b, 30'(v), off, ws, we);
  endfunction

  function automatic hit_t random_hit();
    hit_t        h;
    logic [63:0] ws, we, at, span;
    logic [30:0] off;
    int          b, r, r2;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      h.board = 5'($urandom);
      h.ns = 30'($urandom);
      h.off = 31'($urandom);
      h.ws = {$urandom, $urandom};
      h.we = {$urandom, $urandom};
      return h;
    end
    now_ns += $urandom_range(0, 3000000);
    b = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 31);
    ws = now_ns - $urandom_range(0, 300000000);
    we = now_ns + $urandom_range(0, 300000000);
    span = we - ws;
    if (r < 25) at = last_at[b];
    else if (r < 40)
      at = $urandom_range(0, 1) ? ws - $urandom_range(1, 60000000)
                                : we + $urandom_range(1, 60000000);
    else at = ws + $urandom_range(0, 32'(span));
    r2 = $urandom_range(0, 9);
    if (r2 < 2) off = 31'($urandom);
    else if (r2 < 6) off = board_cable[b];
    else off = 31'(int'($urandom_range(0, 1999999998)) - 999999999);
    last_at[b] = at;
    return hit_at(5'(b), at, off, ws, we);
  endfunction

  // Driver: hold each beat until taken, predict on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_hit(cur_hit);
        hits_sent++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (hit_gap > 0) hit_gap--;
        else if (pending_hits.size() != 0) begin
          cur_hit = pending_hits.pop_front();
          busy = 1'b1;
          hit_gap = (hits_sent % 256 >= 128 && hits_sent % 256 < 192) ? 0 : pick_gap();
        end
      end
      s_axis_tvalid <= busy;
      s_axis_tdata <= {6'd0, cur_hit.we, cur_hit.ws, cur_hit.off, cur_hit.ns, cur_hit.board};
    end
  end

  // Monitor: check each result beat, then decide whether to stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("beat with nothing expected", m_axis_tdata[63:0], '0);
        end else begin
          hit_result_t w;
          w = expected_results.pop_front();
          if (m_axis_tuser[0] !== w.accepted)
            report_mismatch("accepted", 64'(m_axis_tuser[0]), 64'(w.accepted));
          if (m_axis_tdata[63:0] !== w.full_ns)
            report_mismatch("full_time_ns", m_axis_tdata[63:0], w.full_ns);
          if (m_axis_tdata[127:64] !== w.seq)
            report_mismatch("sequence_number", m_axis_tdata[127:64], w.seq);
          if (m_axis_tdata[159:128] !== w.drops)
            report_mismatch("dropped_before", 64'(m_axis_tdata[159:128]), 64'(w.drops));
          if (m_axis_tdata[223:160] !== w.prev)
            report_mismatch("previous_accepted_ns", m_axis_tdata[223:160], w.prev);
        end
        // Long hold-off so the pipeline fills and backs up the input
        if (results_seen == 500 || results_seen == 1300) out_hold = HOLD_CYCLES;
      end
      if (out_hold != 0) begin
        out_hold--;
        ready = 1'b0;
      end else if (out_stall != 0) begin
        out_stall--;
        ready = 1'b0;
      end else begin
        if (results_seen % 256 >= 48 && $urandom_range(0, 3) == 0) out_stall = pick_gap();
        ready = 1'b1;
      end
      m_axis_tready <= ready;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [63:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_registers(input bit sync, input bit order, input logic [39:0] tol);
    apb_write(REG_DROP_SYNC, 64'(sync));
    apb_write(REG_DROP_ORDER, 64'(order));
    apb_write(REG_SYNC_TOL, {24'd0, tol});
    drop_sync = sync;
    drop_order = order;
    tol_ns = tol;
  endtask

  // Append a hit to the driver's queue
  task automatic enqueue_hit(input hit_t h);
    pending_hits = {pending_hits, h};
  endtask

  task automatic queue_random(input int n);
    now_ns = $urandom_range(0, 1) ? {$urandom, $urandom} : {32'd0, $urandom} * 64'd7;
    repeat (n) enqueue_hit(random_hit());
  endtask

  // Wait until every beat has been sent and checked, then let the pipeline settle
  task automatic wait_drain();
    while (pending_hits.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  localparam logic [63:0] T0 = 64'd5000000000;
  localparam logic [63:0] W0 = 64'd7000000100;
  localparam logic [63:0] W1 = 64'd7200000000;
  localparam logic [63:0] X0 = 64'hF000_0000_0000_0000;

  initial begin
    for (int i = 0; i < 32; i++) begin
      board_last_ns[i] = '0;
      board_drops[i] = '0;
      last_at[i] = '0;
      board_cable[i] = 31'(int'($urandom_range(0, 1999999998)) - 999999999);
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // No filtering: field extremes, sign fold, second placement around half a second
    set_registers(1'b0, 1'b0, 40'd0);
    enqueue_hit(make_hit(5'd0, 30'd0, 31'd0, 64'd0, 64'd0));
    enqueue_hit(make_hit(5'd31, 30'd999999999, 31'd999999999, 64'd0, 64'd0));
    enqueue_hit(make_hit(5'd5, 30'd0, 31'(-999999999), 64'd3000000000,
                         64'd3000000000));
    enqueue_hit(make_hit(5'd6, '1, 31'h3FFF_FFFF, '1, '1));
    enqueue_hit(make_hit(5'd7, '1, 31'h4000_0000, 64'd0, '1));
    enqueue_hit(make_hit(5'd1, 30'd500000000, 31'd0, T0, T0));
    enqueue_hit(make_hit(5'd1, 30'd500000001, 31'd0, T0, T0));
    enqueue_hit(make_hit(5'd1, 30'd499999999, 31'd0, T0 + 64'd999999999,
                         T0 + 64'd1000000000));
    enqueue_hit(make_hit(5'd1, 30'd499999998, 31'd0, T0 + 64'd999999999,
                         T0 + 64'd1000000000));
    enqueue_hit(make_hit(5'd1, 30'd0, 31'd0, T0, T0));
    queue_random(300);
    wait_drain();

    // Window filter with no tolerance: just outside and exactly on each edge
    set_registers(1'b1, 1'b0, 40'd0);
    enqueue_hit(hit_at(5'd2, W0 - 64'd1, 31'd12345, W0, W1));
    enqueue_hit(hit_at(5'd2, W0, 31'd12345, W0, W1));
    enqueue_hit(hit_at(5'd2, W1 + 64'd1, 31'd12345, W0, W1));
    enqueue_hit(hit_at(5'd2, W1, 31'd12345, W0, W1));
    queue_random(350);
    wait_drain();

    // Order filter: equal time dropped, one nanosecond later taken
    set_registers(1'b0, 1'b1, {8'($urandom), 32'($urandom)});
    enqueue_hit(hit_at(5'd4, X0, 31'd777, X0, X0));
    enqueue_hit(hit_at(5'd4, X0, 31'd777, X0, X0));
    enqueue_hit(hit_at(5'd4, X0 + 64'd1, 31'd777, X0, X0));
    queue_random(350);
    wait_drain();

    // Largest tolerance: both window bounds saturate
    set_registers(1'b1, 1'b1, '1);
    enqueue_hit(hit_at(5'd8, 64'd5, 31'd0, 64'd10, 64'd20));
    enqueue_hit(hit_at(5'd9, 64'hFFFF_FFFF_FFFF_FFF3, 31'd0,
                       64'hFFFF_FFFF_FFFF_FFF0, 64'hFFFF_FFFF_FFFF_FFF0));
    queue_random(300);
    wait_drain();

    set_registers(1'b1, 1'b1, 40'($urandom_range(0, 50000000)));
    queue_random(400);
    wait_drain();

    $display("Checked %0d hits over five register settings: %0d kept, %0d dropped",
             results_seen, kept_total, dropped_total);
    $display("Output held off twice for %0d cycles while hits kept arriving", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
